[rtl/rgbd_gradient_patch_distance_defines.svh]
// Assertion macros used by the control state machine of the patch distance block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RGBD_GRADIENT_PATCH_DISTANCE_DEFINES_SVH
`define RGBD_GRADIENT_PATCH_DISTANCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgpd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgpd: next-cycle check failed");

`endif

[rtl/rgpd_pkg.sv]
`default_nettype none

package rgpd_pkg;

    localparam int MAX_PATCH_SIDE = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam int LAMBDA_W = 17;
    localparam logic [LAMBDA_W-1:0] LAMBDA_ONE = 17'd65536;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 17'd32768;

    localparam int SIDE_W = 5;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd5;
    localparam int AREA_W = 2 * SIDE_W;

    localparam int WEIGHT_W = 16;
    localparam int CHANNEL_W = 2;
    localparam logic [CHANNEL_W-1:0] CH_DEPTH = 2'd3;

    localparam int SUM_W = 64;
    localparam int HALF_W = SUM_W / 2;
    localparam int PROD_W = HALF_W + LAMBDA_W;
    localparam int ACC_W = 83;
    localparam int NUM_W = ACC_W - HALF_W;
    localparam int DIST_W = 48;

    localparam int BLEND_STEPS = 8;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        REG_LAMBDA_COLOR = 2'd0,
        REG_LAMBDA_DEPTH = 2'd1,
        REG_PATCH_WIDTH  = 2'd2,
        REG_PATCH_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SUM_COLOR      = 2'd0,
        SUM_COLOR_GRAD = 2'd1,
        SUM_DEPTH      = 2'd2,
        SUM_DEPTH_GRAD = 2'd3
    } sum_sel_t;

    typedef struct packed {
        logic [LAMBDA_W-1:0] lambda_color;
        logic [LAMBDA_W-1:0] lambda_depth;
        logic [SIDE_W-1:0]   patch_width;
        logic [SIDE_W-1:0]   patch_height;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       square;
        logic       weight;
        logic       accum;
        logic       blend_clr;
        logic       blend_mul;
        logic       blend_add;
        logic [2:0] blend_sel;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

`default_nettype wire

[rtl/rgbd_gradient_patch_distance.sv]
// Weighted patch distance over RGB-D samples with gradient terms.
// The slave stream carries one channel of one patch pixel per transfer:
// six samples and the pixel weight in s_tdata, the channel number in s_tuser
// (3 selects the depth sums) and the end of the patch on s_tlast.
// Every transfer is accepted in the idle state, then squared, weighted and
// accumulated, each a registered stage driven by the control state machine.
// On the transfer with s_tlast set, the four sums are blended through one
// shared 32 x 17 multiplier and divided by the patch area in a
// one-bit-per-cycle restoring divider; m_tvalid rises as the state machine
// returns to idle, where the next transfer can already be taken. The sums
// clear as the result is loaded into the output register.
// The output register holds a result until the receiver takes it; further
// transfers are still accepted meanwhile, and only the next result waits
// for the register to free up. The APB registers are written by the user
// only while idle; the block does not enforce it. Reset restores the
// register defaults, clears the sums and empties the output register;
// there is no clearing pass.
`default_nettype none

module rgbd_gradient_patch_distance #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rgpd_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [rgpd_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [rgpd_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // color_src, color_dst, grad_x_src, grad_x_dst, grad_y_src, grad_y_dst,
    // pixel_weight, then zero padding to whole bytes.
    input  logic [((6 * SAMPLE_BITS + rgpd_pkg::WEIGHT_W + 7) / 8) * 8 - 1:0] s_tdata,
    // channel.
    input  logic [rgpd_pkg::CHANNEL_W-1:0]        s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // distance.
    output logic [rgpd_pkg::DIST_W-1:0]           m_tdata,
    // saturated.
    output logic                                  m_tuser
);
    import rgpd_pkg::*;

    localparam int SB = SAMPLE_BITS;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    rgpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rgpd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .color_src    (s_tdata[SB-1:0]),
        .color_dst    (s_tdata[2*SB-1:SB]),
        .grad_x_src   (s_tdata[3*SB-1:2*SB]),
        .grad_x_dst   (s_tdata[4*SB-1:3*SB]),
        .grad_y_src   (s_tdata[5*SB-1:4*SB]),
        .grad_y_dst   (s_tdata[6*SB-1:5*SB]),
        .pixel_weight (s_tdata[6*SB+WEIGHT_W-1:6*SB]),
        .channel      (s_tuser),
        .last         (s_tlast),
        .distance     (m_tdata),
        .saturated    (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/rgpd_regs.sv]
`default_nettype none

module rgpd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgpd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rgpd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rgpd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rgpd_pkg::cfg_t                   cfg
);
    import rgpd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lambda_color <= LAMBDA_RESET;
            cfg_reg.lambda_depth <= LAMBDA_RESET;
            cfg_reg.patch_width  <= SIDE_RESET;
            cfg_reg.patch_height <= SIDE_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LAMBDA_COLOR: cfg_reg.lambda_color <= pwdata[LAMBDA_W-1:0];
                REG_LAMBDA_DEPTH: cfg_reg.lambda_depth <= pwdata[LAMBDA_W-1:0];
                REG_PATCH_WIDTH:  cfg_reg.patch_width  <= pwdata[SIDE_W-1:0];
                REG_PATCH_HEIGHT: cfg_reg.patch_height <= pwdata[SIDE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LAMBDA_COLOR: prdata = CFG_DATA_W'(cfg_reg.lambda_color);
            REG_LAMBDA_DEPTH: prdata = CFG_DATA_W'(cfg_reg.lambda_depth);
            REG_PATCH_WIDTH:  prdata = CFG_DATA_W'(cfg_reg.patch_width);
            REG_PATCH_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.patch_height);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/rgpd_datapath.sv]
`default_nettype none

module rgpd_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgpd_pkg::cfg_t                    cfg,
    input  rgpd_pkg::cmd_t                    cmd,
    output rgpd_pkg::status_t                 status,
    input  logic [SAMPLE_BITS-1:0]            color_src,
    input  logic [SAMPLE_BITS-1:0]            color_dst,
    input  logic [SAMPLE_BITS-1:0]            grad_x_src,
    input  logic [SAMPLE_BITS-1:0]            grad_x_dst,
    input  logic [SAMPLE_BITS-1:0]            grad_y_src,
    input  logic [SAMPLE_BITS-1:0]            grad_y_dst,
    input  logic [rgpd_pkg::WEIGHT_W-1:0]     pixel_weight,
    input  logic [rgpd_pkg::CHANNEL_W-1:0]    channel,
    input  logic                              last,
    output logic [rgpd_pkg::DIST_W-1:0]       distance,
    output logic                              saturated
);
    import rgpd_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int SQ_W    = 2 * SB + 2;
    localparam int GSQ_W   = SQ_W + 1;
    localparam int PW_RAW  = GSQ_W + WEIGHT_W;
    localparam int PW      = (PW_RAW > SUM_W + 1) ? PW_RAW : SUM_W + 1;

    function automatic logic [SB:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
        logic signed [SB:0] d;
        d = $signed({a[SB-1], a}) - $signed({b[SB-1], b});
        return d[SB] ? (SB + 1)'(-d) : (SB + 1)'(d);
    endfunction

    function automatic logic [SUM_W-1:0] sat_term(input logic [PW-1:0] p);
        return (|p[PW-1:SUM_W]) ? {SUM_W{1'b1}} : p[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
        if (s == '0)
            return SIDE_W'(1);
        else if (int'(s) > MAX_PATCH_SIDE)
            return SIDE_W'(MAX_PATCH_SIDE);
        else
            return s;
    endfunction

    logic [SB-1:0]        color_src_reg, color_dst_reg;
    logic [SB-1:0]        grad_x_src_reg, grad_x_dst_reg;
    logic [SB-1:0]        grad_y_src_reg, grad_y_dst_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [CHANNEL_W-1:0] channel_reg;
    logic                 last_reg;

    logic [SQ_W-1:0]      csq_reg;
    logic [GSQ_W-1:0]     gsq_reg;
    logic [SUM_W-1:0]     cterm_reg, gterm_reg;

    logic [SUM_W-1:0]     sum_color_reg, sum_depth_reg;
    logic [SUM_W-1:0]     sum_color_grad_reg, sum_depth_grad_reg;

    logic [PROD_W-1:0]    prod_reg;
    logic                 prod_hi_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [NUM_W-1:0]     numq_reg;
    logic [AREA_W-1:0]    rem_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic                 sat_reg;

    logic [SQ_W-1:0]      mc_ext, mx_ext, my_ext;
    logic [SQ_W-1:0]      csq_next;
    logic [GSQ_W-1:0]     gsq_next;
    logic [PW-1:0]        cprod, gprod;
    logic [LAMBDA_W-1:0]  lr, ld, coef;
    logic [SUM_W-1:0]     blend_sum;
    logic [HALF_W-1:0]    blend_half;
    logic [ACC_W-1:0]     acc_addend;
    logic [AREA_W:0]      trial;
    logic                 trial_ge;
    logic [AREA_W-1:0]    rem_next;
    logic                 over;

    assign mc_ext   = SQ_W'(abs_diff(color_src_reg, color_dst_reg));
    assign mx_ext   = SQ_W'(abs_diff(grad_x_src_reg, grad_x_dst_reg));
    assign my_ext   = SQ_W'(abs_diff(grad_y_src_reg, grad_y_dst_reg));
    assign csq_next = mc_ext * mc_ext;
    assign gsq_next = GSQ_W'(mx_ext * mx_ext) + GSQ_W'(my_ext * my_ext);

    assign cprod = PW'(csq_reg) * PW'(weight_reg);
    assign gprod = PW'(gsq_reg) * PW'(weight_reg);

    assign lr = (cfg.lambda_color > LAMBDA_ONE) ? LAMBDA_ONE : cfg.lambda_color;
    assign ld = (cfg.lambda_depth > LAMBDA_ONE) ? LAMBDA_ONE : cfg.lambda_depth;

    always_comb
    begin
        case (sum_sel_t'(cmd.blend_sel[2:1]))
            SUM_COLOR:
            begin
                blend_sum = sum_color_reg;
                coef      = lr;
            end
            SUM_COLOR_GRAD:
            begin
                blend_sum = sum_color_grad_reg;
                coef      = LAMBDA_ONE - lr;
            end
            SUM_DEPTH:
            begin
                blend_sum = sum_depth_reg;
                coef      = ld;
            end
            SUM_DEPTH_GRAD:
            begin
                blend_sum = sum_depth_grad_reg;
                coef      = LAMBDA_ONE - ld;
            end
            default:
            begin
                blend_sum = '0;
                coef      = '0;
            end
        endcase
    end

    assign blend_half = cmd.blend_sel[0] ? blend_sum[SUM_W-1:HALF_W] : blend_sum[HALF_W-1:0];
    assign acc_addend = prod_hi_reg ? ACC_W'({prod_reg, {HALF_W{1'b0}}}) : ACC_W'(prod_reg);

    // One restoring division step per cycle; the quotient bits shift in
    // behind the numerator bits as they are consumed.
    assign trial    = {rem_reg, numq_reg[NUM_W-1]};
    assign trial_ge = trial >= {1'b0, area_reg};
    assign rem_next = trial_ge ? AREA_W'(trial - {1'b0, area_reg}) : AREA_W'(trial);

    assign over = |numq_reg[NUM_W-1:DIST_W];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            color_src_reg  <= color_src;
            color_dst_reg  <= color_dst;
            grad_x_src_reg <= grad_x_src;
            grad_x_dst_reg <= grad_x_dst;
            grad_y_src_reg <= grad_y_src;
            grad_y_dst_reg <= grad_y_dst;
            weight_reg     <= pixel_weight;
            channel_reg    <= channel;
            last_reg       <= last;
        end
        if (cmd.square)
        begin
            csq_reg <= csq_next;
            gsq_reg <= gsq_next;
        end
        if (cmd.weight)
        begin
            cterm_reg <= sat_term(cprod);
            gterm_reg <= sat_term(gprod);
        end
        if (cmd.blend_mul)
        begin
            prod_reg    <= PROD_W'(blend_half) * PROD_W'(coef);
            prod_hi_reg <= cmd.blend_sel[0];
        end
        if (cmd.blend_clr)
            acc_reg <= '0;
        else if (cmd.blend_add)
            acc_reg <= acc_reg + acc_addend;
        if (cmd.div_init)
        begin
            numq_reg <= acc_reg[ACC_W-1:HALF_W];
            rem_reg  <= '0;
            area_reg <= AREA_W'(clamp_side(cfg.patch_width)) *
                        AREA_W'(clamp_side(cfg.patch_height));
        end
        else if (cmd.div_step)
        begin
            numq_reg <= {numq_reg[NUM_W-2:0], trial_ge};
            rem_reg  <= rem_next;
        end
        if (cmd.out_load)
        begin
            dist_reg <= over ? {DIST_W{1'b1}} : numq_reg[DIST_W-1:0];
            sat_reg  <= over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_color_reg      <= '0;
            sum_depth_reg      <= '0;
            sum_color_grad_reg <= '0;
            sum_depth_grad_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            sum_color_reg      <= '0;
            sum_depth_reg      <= '0;
            sum_color_grad_reg <= '0;
            sum_depth_grad_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (channel_reg == CH_DEPTH)
            begin
                sum_depth_reg      <= sat_add(sum_depth_reg, cterm_reg);
                sum_depth_grad_reg <= sat_add(sum_depth_grad_reg, gterm_reg);
            end
            else
            begin
                sum_color_reg      <= sat_add(sum_color_reg, cterm_reg);
                sum_color_grad_reg <= sat_add(sum_color_grad_reg, gterm_reg);
            end
        end
    end

    assign status.last = last_reg;
    assign distance    = dist_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

[rtl/rgpd_ctrl.sv]
`default_nettype none
`include "rgbd_gradient_patch_distance_defines.svh"

module rgpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rgpd_pkg::status_t status,
    output rgpd_pkg::cmd_t    cmd
);
    import rgpd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQR   = 7'b0000010,
        ST_WGT   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_BLEND = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SQR;
                end
            end
            ST_SQR:
            begin
                cmd.square = 1'b1;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                cmd.weight = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accum = 1'b1;
                if (status.last)
                begin
                    cmd.blend_clr = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_BLEND;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLEND:
            begin
                // The product of one step is added in the next, so the last
                // step only drains the product register.
                cmd.blend_sel = cnt_reg[2:0];
                cmd.blend_mul = cnt_reg < CNT_W'(BLEND_STEPS);
                cmd.blend_add = cnt_reg != '0;
                if (cnt_reg == CNT_W'(BLEND_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_init = cnt_reg == '0;
                cmd.div_step = cnt_reg != '0;
                if (cnt_reg == CNT_W'(DIV_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `RGPD_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, !out_valid_reg || m_tready)
    `RGPD_ASSERT_IMPL(a_valid_from_out, $rose(out_valid_reg), $past(state_reg == ST_OUT))
    `RGPD_ASSERT_IMPL(a_blend_count, state_reg == ST_BLEND, cnt_reg <= CNT_W'(BLEND_STEPS))
    `RGPD_ASSERT_NEXT(a_div_to_out, (state_reg == ST_DIV) && (cnt_reg == CNT_W'(DIV_STEPS)), state_reg == ST_OUT)

endmodule

`default_nettype wire
